// ----- rtl/wmsc_pkg.sv -----
// ============================================================================
// wmsc_pkg
// Shared types and constants for the watch mode, stopwatch and countdown block.
// ============================================================================
package wmsc_pkg;

    typedef enum logic [1:0] {
        CMD_KEY     = 2'd0,
        CMD_SW_TICK = 2'd1,
        CMD_CD_TICK = 2'd2,
        CMD_LOAD    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_MAIN      = 3'd0,
        MODE_TIMER     = 3'd1,
        MODE_STOPWATCH = 3'd2,
        MODE_ANALOG    = 3'd3,
        MODE_ALARM     = 3'd4,
        MODE_RECEIVE   = 3'd5,
        MODE_SEND      = 3'd6
    } mode_t;

    localparam logic [7:0] KEY_R = 8'h52;
    localparam logic [7:0] KEY_F = 8'h46;
    localparam logic [7:0] KEY_B = 8'h42;
    localparam logic [7:0] KEY_L = 8'h4C;
    localparam logic [7:0] KEY_C = 8'h43;
    localparam logic [7:0] KEY_X = 8'h58;
    localparam logic [7:0] KEY_T = 8'h54;
    localparam logic [7:0] KEY_S = 8'h53;
    localparam logic [7:0] KEY_A = 8'h41;
    localparam logic [7:0] KEY_P = 8'h50;

    localparam logic [6:0] MAX_99 = 7'd99;
    localparam logic [5:0] MAX_59 = 6'd59;
    localparam logic [6:0] CD_59  = 7'd59;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] key_code;
        logic [6:0] load_hours;
        logic [6:0] load_minutes;
        logic [6:0] load_seconds;
    } item_t;

    typedef struct packed {
        mode_t      mode;
        logic       sw_running;
        logic [6:0] sw_mins;
        logic [5:0] sw_secs;
        logic [6:0] sw_hundredths;
        logic       cd_running;
        logic [6:0] cd_hours;
        logic [6:0] cd_minutes;
        logic [6:0] cd_seconds;
        logic       cd_expired;
    } result_t;

    function automatic logic [6:0] sat99(input logic [6:0] v);
        sat99 = (v > MAX_99) ? MAX_99 : v;
    endfunction

endpackage

// ----- rtl/wmsc_core.sv -----
// ============================================================================
// wmsc_core
// Mode, stopwatch and countdown state with the update for one event.
// ============================================================================
module wmsc_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  wmsc_pkg::item_t   item,
    output wmsc_pkg::result_t res
);

    wmsc_pkg::mode_t mode_reg, mode_next;
    logic       sw_run_reg, sw_run_next;
    logic [6:0] sw_min_reg, sw_min_next;
    logic [5:0] sw_sec_reg, sw_sec_next;
    logic [6:0] sw_hun_reg, sw_hun_next;
    logic       cd_run_reg, cd_run_next;
    logic [6:0] cd_hr_reg, cd_hr_next;
    logic [6:0] cd_min_reg, cd_min_next;
    logic [6:0] cd_sec_reg, cd_sec_next;
    logic       expired;
    logic       cd_zero;

    assign cd_zero = (cd_hr_reg == 7'd0) && (cd_min_reg == 7'd0) && (cd_sec_reg == 7'd0);

    always_comb
    begin
        mode_next   = mode_reg;
        sw_run_next = sw_run_reg;
        sw_min_next = sw_min_reg;
        sw_sec_next = sw_sec_reg;
        sw_hun_next = sw_hun_reg;
        cd_run_next = cd_run_reg;
        cd_hr_next  = cd_hr_reg;
        cd_min_next = cd_min_reg;
        cd_sec_next = cd_sec_reg;
        expired     = 1'b0;
        case (item.cmd)
            wmsc_pkg::CMD_KEY:
            begin
                case (item.key_code)
                    wmsc_pkg::KEY_R: mode_next = wmsc_pkg::MODE_MAIN;
                    wmsc_pkg::KEY_F: mode_next = wmsc_pkg::MODE_TIMER;
                    wmsc_pkg::KEY_B: mode_next = wmsc_pkg::MODE_STOPWATCH;
                    wmsc_pkg::KEY_L: mode_next = wmsc_pkg::MODE_ANALOG;
                    wmsc_pkg::KEY_C: mode_next = wmsc_pkg::MODE_ALARM;
                    wmsc_pkg::KEY_X: mode_next = wmsc_pkg::MODE_RECEIVE;
                    wmsc_pkg::KEY_T: mode_next = wmsc_pkg::MODE_SEND;
                    wmsc_pkg::KEY_S:
                    begin
                        if (mode_reg == wmsc_pkg::MODE_STOPWATCH)
                        begin
                            sw_run_next = 1'b0;
                            sw_min_next = 7'd0;
                            sw_sec_next = 6'd0;
                            sw_hun_next = 7'd0;
                        end
                        else if (mode_reg == wmsc_pkg::MODE_TIMER)
                        begin
                            cd_run_next = 1'b0;
                            cd_hr_next  = 7'd0;
                            cd_min_next = 7'd0;
                            cd_sec_next = 7'd0;
                        end
                    end
                    wmsc_pkg::KEY_A:
                    begin
                        if (mode_reg == wmsc_pkg::MODE_STOPWATCH)
                            sw_run_next = 1'b1;
                        else if (mode_reg == wmsc_pkg::MODE_TIMER)
                            cd_run_next = !cd_zero;
                    end
                    wmsc_pkg::KEY_P:
                    begin
                        if (mode_reg == wmsc_pkg::MODE_STOPWATCH)
                            sw_run_next = 1'b0;
                        else if (mode_reg == wmsc_pkg::MODE_TIMER)
                            cd_run_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            wmsc_pkg::CMD_SW_TICK:
            begin
                if (sw_run_reg)
                begin
                    if (sw_hun_reg >= wmsc_pkg::MAX_99)
                    begin
                        sw_hun_next = 7'd0;
                        if (sw_sec_reg >= wmsc_pkg::MAX_59)
                        begin
                            sw_sec_next = 6'd0;
                            sw_min_next = (sw_min_reg >= wmsc_pkg::MAX_99) ? 7'd0
                                                                           : sw_min_reg + 7'd1;
                        end
                        else
                            sw_sec_next = sw_sec_reg + 6'd1;
                    end
                    else
                        sw_hun_next = sw_hun_reg + 7'd1;
                end
            end
            wmsc_pkg::CMD_CD_TICK:
            begin
                if (cd_run_reg)
                begin
                    if (cd_sec_reg != 7'd0)
                        cd_sec_next = cd_sec_reg - 7'd1;
                    else if (cd_min_reg != 7'd0)
                    begin
                        cd_min_next = cd_min_reg - 7'd1;
                        cd_sec_next = wmsc_pkg::CD_59;
                    end
                    else if (cd_hr_reg != 7'd0)
                    begin
                        cd_hr_next  = cd_hr_reg - 7'd1;
                        cd_min_next = wmsc_pkg::CD_59;
                        cd_sec_next = wmsc_pkg::CD_59;
                    end
                    else
                    begin
                        cd_run_next = 1'b0;
                        expired     = 1'b1;
                    end
                end
            end
            wmsc_pkg::CMD_LOAD:
            begin
                cd_hr_next  = wmsc_pkg::sat99(item.load_hours);
                cd_min_next = wmsc_pkg::sat99(item.load_minutes);
                cd_sec_next = wmsc_pkg::sat99(item.load_seconds);
                cd_run_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= wmsc_pkg::MODE_MAIN;
            sw_run_reg <= 1'b0;
            sw_min_reg <= 7'd0;
            sw_sec_reg <= 6'd0;
            sw_hun_reg <= 7'd0;
            cd_run_reg <= 1'b0;
            cd_hr_reg  <= 7'd0;
            cd_min_reg <= 7'd0;
            cd_sec_reg <= 7'd0;
        end
        else if (en)
        begin
            mode_reg   <= mode_next;
            sw_run_reg <= sw_run_next;
            sw_min_reg <= sw_min_next;
            sw_sec_reg <= sw_sec_next;
            sw_hun_reg <= sw_hun_next;
            cd_run_reg <= cd_run_next;
            cd_hr_reg  <= cd_hr_next;
            cd_min_reg <= cd_min_next;
            cd_sec_reg <= cd_sec_next;
        end
    end

    always_comb
    begin
        res.mode          = mode_next;
        res.sw_running    = sw_run_next;
        res.sw_mins       = sw_min_next;
        res.sw_secs       = sw_sec_next;
        res.sw_hundredths = sw_hun_next;
        res.cd_running    = cd_run_next;
        res.cd_hours      = cd_hr_next;
        res.cd_minutes    = cd_min_next;
        res.cd_seconds    = cd_sec_next;
        res.cd_expired    = expired;
    end

endmodule

// ----- rtl/watch_mode_stopwatch_countdown_top.sv -----
// ============================================================================
// watch_mode_stopwatch_countdown_top
// Watch mode controller with a stopwatch and a countdown timer.
// ============================================================================
// Each input word is one event (key press, stopwatch tick, countdown tick or
// countdown load) and yields exactly one result word with the mode, both
// counters and the expiry flag as they stand after that event. Words are
// taken one per clock while the sink takes results; an accepted word lands in
// the input register and, once the result register is free or being emptied,
// is applied to the state and loaded into the result register at the same
// edge. The input register holds a word back while the result register is
// full, and the result register frees itself in the same cycle the sink
// takes its word.
module watch_mode_stopwatch_countdown_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // key_code, load_hours, load_minutes, load_seconds, zero pad
    input  logic [1:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // mode, sw_running, sw_mins, sw_secs,
                                  // sw_hundredths, cd_running, cd_hours,
                                  // cd_minutes, cd_seconds, cd_expired, zero pad
);

    wmsc_pkg::item_t   item_reg;
    logic              in_valid_reg;
    wmsc_pkg::result_t res_next;
    wmsc_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cmd          <= wmsc_pkg::cmd_t'(s_tuser);
            item_reg.key_code     <= s_tdata[7:0];
            item_reg.load_hours   <= s_tdata[14:8];
            item_reg.load_minutes <= s_tdata[21:15];
            item_reg.load_seconds <= s_tdata[28:22];
        end
        if (advance)
            res_reg <= res_next;
    end

    wmsc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (item_reg),
        .res   (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       res_reg.cd_expired,
                       res_reg.cd_seconds,
                       res_reg.cd_minutes,
                       res_reg.cd_hours,
                       res_reg.cd_running,
                       res_reg.sw_hundredths,
                       res_reg.sw_secs,
                       res_reg.sw_mins,
                       res_reg.sw_running,
                       res_reg.mode};

`ifndef SYNTHESIS
    // An expired countdown has stopped and sits at zero.
    a_expired_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[46]) |->
            (!m_tdata[24] && m_tdata[31:25] == 7'd0 && m_tdata[38:32] == 7'd0
             && m_tdata[45:39] == 7'd0))
        else $error("countdown expired while running or nonzero");

    // The stopwatch fields stay in their decimal ranges.
    a_sw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:11] < 6'd60 && m_tdata[23:17] < 7'd100
                      && m_tdata[10:4] < 7'd100))
        else $error("stopwatch field out of range");

    // A running countdown has time left or was already running, so it never starts at zero.
    a_cd_running_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |->
            (m_tdata[31:25] != 7'd0 || m_tdata[38:32] != 7'd0 || m_tdata[45:39] != 7'd0
             || $past(m_tdata[24])))
        else $error("countdown started at zero");
`endif

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// Watch mode, stopwatch and countdown regression
// Drives event words into the block through the slave stream, predicts the
// mode, stopwatch and countdown state after each one, and compares every
// result word field by field. The run covers directed corner cases, a
// full-rate stopwatch run across two seconds carries, and random traffic
// with bursty input and a stalling sink.
// ============================================================================
module testbench;

    class watch_scoreboard;
        wmsc_pkg::mode_t   mode;
        bit                sw_run;
        bit [6:0]          sw_min;
        bit [5:0]          sw_sec;
        bit [6:0]          sw_hund;
        bit                cd_run;
        bit [6:0]          cd_h;
        bit [6:0]          cd_m;
        bit [6:0]          cd_s;
        wmsc_pkg::result_t expected_words[$];
        int                errors;

        function new();
            mode    = wmsc_pkg::MODE_MAIN;
            sw_run  = 1'b0;
            sw_min  = '0;
            sw_sec  = '0;
            sw_hund = '0;
            cd_run  = 1'b0;
            cd_h    = '0;
            cd_m    = '0;
            cd_s    = '0;
            errors  = 0;
        endfunction

        function void apply_key(logic [7:0] key);
            case (key)
                wmsc_pkg::KEY_R: mode = wmsc_pkg::MODE_MAIN;
                wmsc_pkg::KEY_F: mode = wmsc_pkg::MODE_TIMER;
                wmsc_pkg::KEY_B: mode = wmsc_pkg::MODE_STOPWATCH;
                wmsc_pkg::KEY_L: mode = wmsc_pkg::MODE_ANALOG;
                wmsc_pkg::KEY_C: mode = wmsc_pkg::MODE_ALARM;
                wmsc_pkg::KEY_X: mode = wmsc_pkg::MODE_RECEIVE;
                wmsc_pkg::KEY_T: mode = wmsc_pkg::MODE_SEND;
                wmsc_pkg::KEY_S:
                begin
                    if (mode == wmsc_pkg::MODE_STOPWATCH)
                    begin
                        sw_run  = 1'b0;
                        sw_min  = '0;
                        sw_sec  = '0;
                        sw_hund = '0;
                    end
                    else if (mode == wmsc_pkg::MODE_TIMER)
                    begin
                        cd_run = 1'b0;
                        cd_h   = '0;
                        cd_m   = '0;
                        cd_s   = '0;
                    end
                end
                wmsc_pkg::KEY_A:
                begin
                    if (mode == wmsc_pkg::MODE_STOPWATCH)
                        sw_run = 1'b1;
                    else if (mode == wmsc_pkg::MODE_TIMER)
                        cd_run = (cd_h != 0) || (cd_m != 0) || (cd_s != 0);
                end
                wmsc_pkg::KEY_P:
                begin
                    if (mode == wmsc_pkg::MODE_STOPWATCH)
                        sw_run = 1'b0;
                    else if (mode == wmsc_pkg::MODE_TIMER)
                        cd_run = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void note_event(wmsc_pkg::cmd_t cmd, logic [7:0] key,
                                 logic [6:0] h, logic [6:0] m, logic [6:0] s);
            wmsc_pkg::result_t w;
            bit                expired;
            expired = 1'b0;
            case (cmd)
                wmsc_pkg::CMD_KEY: apply_key(key);
                wmsc_pkg::CMD_SW_TICK:
                begin
                    if (sw_run)
                    begin
                        if (sw_hund == wmsc_pkg::MAX_99)
                        begin
                            sw_hund = '0;
                            if (sw_sec == wmsc_pkg::MAX_59)
                            begin
                                sw_sec = '0;
                                sw_min = (sw_min == wmsc_pkg::MAX_99) ? 7'd0 : sw_min + 7'd1;
                            end
                            else
                                sw_sec = sw_sec + 6'd1;
                        end
                        else
                            sw_hund = sw_hund + 7'd1;
                    end
                end
                wmsc_pkg::CMD_CD_TICK:
                begin
                    if (cd_run)
                    begin
                        if (cd_s != 0)
                            cd_s = cd_s - 7'd1;
                        else if (cd_m != 0)
                        begin
                            cd_m = cd_m - 7'd1;
                            cd_s = wmsc_pkg::CD_59;
                        end
                        else if (cd_h != 0)
                        begin
                            cd_h = cd_h - 7'd1;
                            cd_m = wmsc_pkg::CD_59;
                            cd_s = wmsc_pkg::CD_59;
                        end
                        else
                        begin
                            cd_run  = 1'b0;
                            expired = 1'b1;
                        end
                    end
                end
                default:
                begin
                    cd_h   = (h > wmsc_pkg::MAX_99) ? wmsc_pkg::MAX_99 : h;
                    cd_m   = (m > wmsc_pkg::MAX_99) ? wmsc_pkg::MAX_99 : m;
                    cd_s   = (s > wmsc_pkg::MAX_99) ? wmsc_pkg::MAX_99 : s;
                    cd_run = 1'b0;
                end
            endcase
            w.mode          = mode;
            w.sw_running    = sw_run;
            w.sw_mins       = sw_min;
            w.sw_secs       = sw_sec;
            w.sw_hundredths = sw_hund;
            w.cd_running    = cd_run;
            w.cd_hours      = cd_h;
            w.cd_minutes    = cd_m;
            w.cd_seconds    = cd_s;
            w.cd_expired    = expired;
            expected_words.push_back(w);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [47:0] data);
            wmsc_pkg::result_t w;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result word %h", data);
                return;
            end
            w = expected_words.pop_front();
            check_field("mode", w.mode, data[2:0]);
            check_field("sw_running", w.sw_running, data[3]);
            check_field("stopwatch minutes", w.sw_mins, data[10:4]);
            check_field("stopwatch seconds", w.sw_secs, data[16:11]);
            check_field("sw_hundredths", w.sw_hundredths, data[23:17]);
            check_field("cd_running", w.cd_running, data[24]);
            check_field("cd_hours", w.cd_hours, data[31:25]);
            check_field("cd_minutes", w.cd_minutes, data[38:32]);
            check_field("cd_seconds", w.cd_seconds, data[45:39]);
            check_field("cd_expired", w.cd_expired, data[46]);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // key_code, load_hours, load_minutes, load_seconds, zero pad
    logic [1:0]  s_tuser  = '0;  // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // mode, sw_running, sw_mins, sw_secs,
                                 // sw_hundredths, cd_running, cd_hours,
                                 // cd_minutes, cd_seconds, cd_expired, zero pad

    watch_scoreboard sb;
    bit              steady     = 1'b0;
    int              burst_left = 0;
    logic [15:0]     stall_bits = '1;
    int              stall_left = 0;

    watch_mode_stopwatch_countdown_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else
        begin
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_bits = '1;
                    1: stall_bits = 16'($urandom);
                    2: stall_bits = 16'($urandom & $urandom);
                    default: stall_bits = 16'($urandom | $urandom);
                endcase
                stall_left = 16;
            end
            m_tready <= stall_bits[0];
            stall_bits = stall_bits >> 1;
            stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic push_event(wmsc_pkg::cmd_t cmd, logic [7:0] key,
                              logic [6:0] h, logic [6:0] m, logic [6:0] s);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, s, m, h, key};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(cmd, key, h, m, s);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic push_key(logic [7:0] key);
        push_event(wmsc_pkg::CMD_KEY, key, 7'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task automatic push_tick(wmsc_pkg::cmd_t cmd);
        push_event(cmd, 8'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task automatic push_load(logic [6:0] h, logic [6:0] m, logic [6:0] s);
        push_event(wmsc_pkg::CMD_LOAD, 8'($urandom), h, m, s);
    endtask

    task automatic push_random_event();
        logic [7:0]     keys [10];
        logic [7:0]     key;
        logic [6:0]     h;
        logic [6:0]     m;
        logic [6:0]     s;
        int             pick;
        wmsc_pkg::cmd_t cmd;
        keys = '{wmsc_pkg::KEY_F, wmsc_pkg::KEY_B, wmsc_pkg::KEY_S, wmsc_pkg::KEY_A,
                 wmsc_pkg::KEY_P, wmsc_pkg::KEY_R, wmsc_pkg::KEY_L, wmsc_pkg::KEY_C,
                 wmsc_pkg::KEY_X, wmsc_pkg::KEY_T};
        key  = 8'($urandom);
        h    = 7'($urandom);
        m    = 7'($urandom);
        s    = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            cmd = wmsc_pkg::CMD_KEY;
            if ($urandom_range(0, 9) != 0)
                key = keys[$urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 9)];
        end
        else if (pick < 55)
            cmd = wmsc_pkg::CMD_SW_TICK;
        else if (pick < 85)
            cmd = wmsc_pkg::CMD_CD_TICK;
        else
        begin
            cmd = wmsc_pkg::CMD_LOAD;
            if ($urandom_range(0, 9) < 7)
            begin
                h = 7'($urandom_range(0, 1));
                m = 7'($urandom_range(0, 2));
                s = 7'($urandom_range(0, 3));
            end
        end
        push_event(cmd, key, h, m, s);
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_key(wmsc_pkg::KEY_L);
        push_key(wmsc_pkg::KEY_C);
        push_key(wmsc_pkg::KEY_X);
        push_key(wmsc_pkg::KEY_T);
        push_key(wmsc_pkg::KEY_S);
        push_key(wmsc_pkg::KEY_A);
        push_key(wmsc_pkg::KEY_P);
        push_key(wmsc_pkg::KEY_F);
        push_key(wmsc_pkg::KEY_A);
        push_tick(wmsc_pkg::CMD_CD_TICK);
        push_load(7'd127, 7'd127, 7'd127);
        push_load(7'd1, 7'd0, 7'd0);
        push_key(wmsc_pkg::KEY_A);
        push_tick(wmsc_pkg::CMD_CD_TICK);
        push_key(wmsc_pkg::KEY_P);
        push_key(wmsc_pkg::KEY_S);
        push_load(7'd0, 7'd0, 7'd1);
        push_key(wmsc_pkg::KEY_A);
        push_tick(wmsc_pkg::CMD_CD_TICK);
        push_tick(wmsc_pkg::CMD_CD_TICK);
        push_key(8'hFF);
        push_key(wmsc_pkg::KEY_B);
        push_tick(wmsc_pkg::CMD_SW_TICK);
        push_key(wmsc_pkg::KEY_A);
        push_tick(wmsc_pkg::CMD_SW_TICK);
        push_key(wmsc_pkg::KEY_P);
        push_key(wmsc_pkg::KEY_S);
        push_key(wmsc_pkg::KEY_R);

        // Run the stopwatch at full rate across two seconds carries.
        steady = 1'b1;
        push_key(wmsc_pkg::KEY_B);
        push_key(wmsc_pkg::KEY_A);
        repeat (250) push_tick(wmsc_pkg::CMD_SW_TICK);
        push_key(wmsc_pkg::KEY_P);
        steady = 1'b0;

        repeat (1520) push_random_event();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
